// ===== src/ptm_pkg.sv =====
// shared types and constants for the page table map/unmap engine
// no dependencies

package ptm_pkg;

	localparam int unsigned IdxBits = 9;
	localparam int unsigned EntriesPerTable = 512;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_MISALIGNED = 3'd1,
		ST_NO_TABLES  = 3'd2,
		ST_LARGE_PAGE = 3'd3,
		ST_MAPPED     = 3'd4
	} status_t;

	localparam logic OP_MAP   = 1'b0;
	localparam logic OP_UNMAP = 1'b1;

	localparam logic KIND_INVAL  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam int unsigned BitP  = 0;
	localparam int unsigned BitPs = 7;

	typedef struct packed {
		logic        operation;
		logic [47:0] virt_addr;
		logic [51:0] phys_addr;
		logic [4:0]  page_count;
		logic [63:0] entry_flags;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic [47:0] address;
		logic [2:0]  status;
		logic        last;
	} rsp_t;

endpackage

// ===== src/ptm_mem.sv =====
// table memory: one write port, one read port, registered read data
// uses ptm_pkg for the entries-per-table constant

module ptm_mem #(
	parameter int unsigned NUM_TABLES = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(NUM_TABLES)+ptm_pkg::IdxBits-1:0] waddr,
	input  logic [63:0] wdata,
	input  logic [$clog2(NUM_TABLES)+ptm_pkg::IdxBits-1:0] raddr,
	output logic [63:0] rdata
);
	import ptm_pkg::*;

	localparam int unsigned Depth = NUM_TABLES * EntriesPerTable;

	logic [63:0] mem_q [Depth];
	logic [63:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/ptm_walk.sv =====
// walk sequencer: clears the memory, walks the levels, allocates, rolls back
// uses ptm_pkg and drives ptm_mem

module ptm_walk #(
	parameter int unsigned NUM_TABLES = 16,
	parameter int unsigned MAX_PAGES  = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  ptm_pkg::req_t in_req,
	input  logic [51:0] base,
	input  logic out_free,
	output logic out_push,
	output ptm_pkg::rsp_t out_rsp,
	output logic mem_we,
	output logic [$clog2(NUM_TABLES)+ptm_pkg::IdxBits-1:0] mem_waddr,
	output logic [63:0] mem_wdata,
	output logic [$clog2(NUM_TABLES)+ptm_pkg::IdxBits-1:0] mem_raddr,
	input  logic [63:0] mem_rdata
);
	import ptm_pkg::*;

	localparam int unsigned TIW = $clog2(NUM_TABLES);
	localparam int unsigned AW  = TIW + IdxBits;
	localparam int unsigned NW  = $clog2(NUM_TABLES + 1);
	localparam int unsigned CW  = $clog2(MAX_PAGES + 1);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_CHECK, S_START, S_RD, S_EVAL,
		S_ZERO, S_LINK, S_FOL, S_EMIT, S_NEXT, S_STATUS
	} state_t;

	state_t state_q;
	logic          op_q, rb_q;
	logic [35:0]   vpn_q;
	logic [39:0]   pfn_q;
	logic [11:0]   va_lo_q, pa_lo_q;
	logic [63:0]   flags_q;
	logic [CW-1:0] cnt_q, page_q, fail_q;
	logic [1:0]    lvl_q;
	logic [TIW-1:0] tbl_q, new_q;
	logic [63:0]   ent_q;
	status_t       status_q;
	logic [NW-1:0] nft_q;
	logic [AW-1:0] sweep_q;

	logic [35:0] vpn_cur;
	logic [39:0] pfn_cur;
	logic [8:0]  idx;
	logic [AW-1:0] addr;
	logic        unmap_mode;
	logic [39:0] diff;
	logic [CW-1:0] page_nx;
	logic [5:0]  cnt_clamp;
	logic [63:0] link_ent;

	assign vpn_cur    = vpn_q + 36'(page_q);
	assign pfn_cur    = pfn_q + 40'(page_q);
	assign unmap_mode = (op_q == OP_UNMAP) || rb_q;
	assign diff       = ent_q[51:12] - base[51:12];
	assign page_nx    = page_q + CW'(1);
	assign cnt_clamp  = ({1'b0, in_req.page_count} > 6'(MAX_PAGES)) ? 6'(MAX_PAGES)
		: {1'b0, in_req.page_count};
	assign link_ent   = {12'd0, base[51:12] + 40'(new_q), 12'h003};

	always_comb begin
		unique case (lvl_q)
			2'd0: idx = vpn_cur[35:27];
			2'd1: idx = vpn_cur[26:18];
			2'd2: idx = vpn_cur[17:9];
			default: idx = vpn_cur[8:0];
		endcase
	end

	assign addr      = {tbl_q, idx};
	assign mem_raddr = addr;
	assign in_stall  = (state_q != S_IDLE);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr;
		mem_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
			end
			S_ZERO: begin
				mem_we    = 1'b1;
				mem_waddr = {new_q, sweep_q[IdxBits-1:0]};
			end
			S_LINK: begin
				mem_we    = 1'b1;
				mem_wdata = link_ent;
			end
			S_EVAL: begin
				if (lvl_q == 2'd3) begin
					if (unmap_mode) begin
						mem_we = mem_rdata[BitP];
					end else begin
						mem_we    = !mem_rdata[BitP];
						mem_wdata = {pfn_cur, 12'd0} | flags_q;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			sweep_q  <= '0;
			nft_q    <= NW'(1);
			out_push <= 1'b0;
			rb_q     <= 1'b0;
		end else begin
			out_push <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == AW'(NUM_TABLES * EntriesPerTable - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= in_req.operation;
						vpn_q   <= in_req.virt_addr[47:12];
						va_lo_q <= in_req.virt_addr[11:0];
						pfn_q   <= in_req.phys_addr[51:12];
						pa_lo_q <= in_req.phys_addr[11:0];
						flags_q <= in_req.entry_flags;
						cnt_q   <= CW'(cnt_clamp);
						rb_q    <= 1'b0;
						page_q  <= '0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					status_q <= ST_OK;
					if (va_lo_q != 12'd0 || (op_q == OP_MAP && pa_lo_q != 12'd0)) begin
						status_q <= ST_MISALIGNED;
						state_q  <= S_STATUS;
					end else if (cnt_q == '0) begin
						state_q <= S_STATUS;
					end else begin
						state_q <= S_START;
					end
				end
				S_START: begin
					lvl_q   <= 2'd0;
					tbl_q   <= '0;
					state_q <= S_RD;
				end
				S_RD: state_q <= S_EVAL;
				S_EVAL: begin
					ent_q <= mem_rdata;
					if (lvl_q == 2'd3) begin
						if (unmap_mode) begin
							state_q <= mem_rdata[BitP] ? S_EMIT : S_NEXT;
						end else if (mem_rdata[BitP]) begin
							status_q <= ST_MAPPED;
							state_q  <= S_NEXT;
						end else begin
							state_q <= S_EMIT;
						end
					end else if (unmap_mode) begin
						if (!mem_rdata[BitP] || (lvl_q != 2'd0 && mem_rdata[BitPs])) begin
							state_q <= S_NEXT;
						end else begin
							state_q <= S_FOL;
						end
					end else if (lvl_q != 2'd0 && mem_rdata[BitPs]) begin
						status_q <= ST_LARGE_PAGE;
						state_q  <= S_NEXT;
					end else if (!mem_rdata[BitP]) begin
						if (nft_q >= NW'(NUM_TABLES)) begin
							status_q <= ST_NO_TABLES;
							state_q  <= S_NEXT;
						end else begin
							new_q   <= nft_q[TIW-1:0];
							nft_q   <= nft_q + NW'(1);
							sweep_q <= '0;
							state_q <= S_ZERO;
						end
					end else begin
						state_q <= S_FOL;
					end
				end
				S_ZERO: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q[IdxBits-1:0] == '1) begin
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					ent_q   <= link_ent;
					state_q <= S_FOL;
				end
				S_FOL: begin
					if (diff >= 40'(NUM_TABLES)) begin
						if (!unmap_mode) begin
							status_q <= ST_NO_TABLES;
						end
						state_q <= S_NEXT;
					end else begin
						tbl_q   <= diff[TIW-1:0];
						lvl_q   <= lvl_q + 2'd1;
						state_q <= S_RD;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_push <= 1'b1;
						out_rsp  <= '{kind: KIND_INVAL, address: {vpn_cur, 12'd0},
							status: ST_OK, last: 1'b0};
						state_q  <= S_NEXT;
					end
				end
				S_NEXT: begin
					// a map failure lands here with a nonzero status
					if (!rb_q && status_q != ST_OK) begin
						if (page_q == '0) begin
							state_q <= S_STATUS;
						end else begin
							rb_q    <= 1'b1;
							fail_q  <= page_q;
							page_q  <= '0;
							state_q <= S_START;
						end
					end else begin
						page_q <= page_nx;
						if (page_nx == (rb_q ? fail_q : cnt_q)) begin
							state_q <= S_STATUS;
						end else begin
							state_q <= S_START;
						end
					end
				end
				S_STATUS: begin
					if (out_free) begin
						out_push <= 1'b1;
						out_rsp  <= '{kind: KIND_STATUS, address: {vpn_q, va_lo_q},
							status: status_q, last: 1'b1};
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== src/page_table_map_unmap_engine.sv =====
// per page a walk down the four levels, with the leaf written or cleared where needed
// (an unmap may stop early); each new table is zeroed and then linked in
// one request at a time: accept, check, the pages, then the final status;
// a rollback repeats the walk for each mapped page; output stalls hold the sequence
// after reset the table memory is cleared, with in_stall high
// table_base resets to zero; the table allocator resets to table one
// uses ptm_pkg, ptm_mem and ptm_walk

module page_table_map_unmap_engine #(
	parameter int unsigned NUM_TABLES = 16,
	parameter int unsigned MAX_PAGES  = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  ptm_pkg::req_t in_req,
	output logic out_valid,
	input  logic out_stall,
	output ptm_pkg::rsp_t out_rsp,
	input  logic cfg_we,
	input  logic [51:0] cfg_wdata
);
	import ptm_pkg::*;

	localparam int unsigned AW = $clog2(NUM_TABLES) + IdxBits;

	logic [51:0] table_base_q;
	logic        out_valid_q;
	rsp_t        out_rsp_q;
	logic        out_free, push;
	rsp_t        push_rsp;
	logic        mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [63:0] mem_wdata, mem_rdata;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_base_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				table_base_q <= cfg_wdata;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_rsp_q <= push_rsp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

	ptm_walk #(
		.NUM_TABLES(NUM_TABLES),
		.MAX_PAGES (MAX_PAGES)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_req   (in_req),
		.base     (table_base_q),
		.out_free (out_free),
		.out_push (push),
		.out_rsp  (push_rsp),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	ptm_mem #(
		.NUM_TABLES(NUM_TABLES)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

// ===== sim/tb_top.sv =====
// testbench for page_table_map_unmap_engine: a predictor of the four-level page walk
// checks every invalidate and status response; uses ptm_pkg and the engine rtl
`timescale 1ns / 1ps

module tb_top;
	import ptm_pkg::*;

	localparam int unsigned NumTables = 16;
	localparam int unsigned MaxPages = 16;
	localparam logic [63:0] EntryAddr = 64'h000F_FFFF_FFFF_F000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	req_t in_req;
	logic out_valid;
	logic out_stall;
	rsp_t out_rsp;
	logic cfg_we;
	logic [51:0] cfg_wdata;

	page_table_map_unmap_engine #(.NUM_TABLES(NumTables), .MAX_PAGES(MaxPages)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
		.out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// predictor state
	logic [63:0] pt_mem [NumTables*512];
	int unsigned free_table;
	logic [51:0] base_reg;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int errors;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;
	bit hold_req;
	bit in_taken;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic logic [51:0] tbl_addr(input int unsigned t);
		return ({base_reg[51:12], 12'h000} + 52'(t) * 52'd4096);
	endfunction

	function automatic int follow_entry(input logic [63:0] e);
		logic [51:0] off;
		off = e[51:0] & EntryAddr[51:0];
		off = off - {base_reg[51:12], 12'h000};
		if (off[51:12] >= NumTables) return -1;
		return int'(off[51:12]);
	endfunction

	function automatic int slot_of(input int t, input logic [47:0] va, input int sh);
		return t * 512 + int'((va >> sh) & 48'h1FF);
	endfunction

	function automatic void push_inval(input logic [47:0] va);
		rsp_t r;
		r = '{kind: KIND_INVAL, address: va, status: ST_OK, last: 1'b0};
		expected_rsps.push_back(r);
	endfunction

	function automatic status_t walk_map(input logic [47:0] va, input logic [51:0] pa,
			input logic [63:0] flags);
		int t;
		int s;
		int lv;
		int sh;
		t = 0;
		for (lv = 0; lv < 3; lv++) begin
			sh = 39 - 9 * lv;
			s = slot_of(t, va, sh);
			if (lv > 0 && pt_mem[s][BitPs]) return ST_LARGE_PAGE;
			if (!pt_mem[s][BitP]) begin
				if (free_table >= NumTables) return ST_NO_TABLES;
				for (int k = 0; k < 512; k++) pt_mem[free_table*512 + k] = '0;
				pt_mem[s] = {12'h0, tbl_addr(free_table)} | 64'h3;
				free_table++;
			end
			t = follow_entry(pt_mem[s]);
			if (t < 0) return ST_NO_TABLES;
		end
		s = slot_of(t, va, 12);
		if (pt_mem[s][BitP]) return ST_MAPPED;
		pt_mem[s] = {12'h0, pa[51:12], 12'h000} | flags;
		push_inval(va);
		return ST_OK;
	endfunction

	function automatic void walk_unmap(input logic [47:0] va);
		int t;
		int s;
		int lv;
		t = 0;
		for (lv = 0; lv < 3; lv++) begin
			s = slot_of(t, va, 39 - 9 * lv);
			if (!pt_mem[s][BitP]) return;
			if (lv > 0 && pt_mem[s][BitPs]) return;
			t = follow_entry(pt_mem[s]);
			if (t < 0) return;
		end
		s = slot_of(t, va, 12);
		if (!pt_mem[s][BitP]) return;
		pt_mem[s] = '0;
		push_inval(va);
	endfunction

	function automatic void predict_request(input req_t rq);
		int unsigned n;
		status_t st;
		rsp_t r;
		n = (rq.page_count > MaxPages) ? MaxPages : rq.page_count;
		st = ST_OK;
		if (rq.operation == OP_MAP) begin
			if (rq.virt_addr[11:0] != 0 || rq.phys_addr[11:0] != 0) begin
				st = ST_MISALIGNED;
			end else begin
				for (int unsigned i = 0; i < n; i++) begin
					st = walk_map(rq.virt_addr + 48'(i) * 48'd4096,
						rq.phys_addr + 52'(i) * 52'd4096, rq.entry_flags);
					if (st != ST_OK) begin
						for (int unsigned j = 0; j < i; j++)
							walk_unmap(rq.virt_addr + 48'(j) * 48'd4096);
						break;
					end
				end
			end
		end else if (rq.virt_addr[11:0] != 0) begin
			st = ST_MISALIGNED;
		end else begin
			for (int unsigned i = 0; i < n; i++)
				walk_unmap(rq.virt_addr + 48'(i) * 48'd4096);
		end
		r = '{kind: KIND_STATUS, address: rq.virt_addr, status: st, last: 1'b1};
		expected_rsps.push_back(r);
	endfunction

	// driver: a new request only once the current one was taken at the last rising edge
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_req <= pending_reqs.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_req && hold_cycles == 0) begin
			hold_cycles <= 3000;
			out_stall <= 1'b1;
		end else if (hold_cycles > 1) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			hold_cycles <= 0;
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// prediction at acceptance, then monitor
	always @(posedge clk) begin
		rsp_t e;
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) predict_request(in_req);
		if (arst_n && out_valid && !out_stall) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected response %p", $time, out_rsp);
				errors++;
			end else begin
				e = expected_rsps.pop_front();
				if (out_rsp.kind !== e.kind || out_rsp.address !== e.address
						|| out_rsp.status !== e.status || out_rsp.last !== e.last) begin
					$display("%0t: mismatch expected %p actual %p", $time, e, out_rsp);
					errors++;
				end
			end
		end
	end

	function automatic req_t mk_req(input logic op, input logic [47:0] va,
			input logic [51:0] pa, input logic [4:0] cnt, input logic [63:0] fl);
		req_t r;
		r.operation = op;
		r.virt_addr = va;
		r.phys_addr = pa;
		r.page_count = cnt;
		r.entry_flags = fl;
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// a few clustered regions so walks share tables and hit mapped pages
	function automatic logic [47:0] rand_va();
		logic [47:0] va;
		va = 48'(rand64());
		va[11:0] = 12'h000;
		case ($urandom_range(3))
			0: va[47:21] = 27'h0000011;
			1: va[47:21] = 27'h0000012;
			2: va[47:21] = 27'h7FF_FFFF;
			default: ;
		endcase
		if ($urandom_range(3) != 0) va[20:16] = 5'h0;
		if ($urandom_range(19) == 0) va[11:0] = 12'($urandom());
		return va;
	endfunction

	function automatic req_t rand_req();
		logic [51:0] pa;
		logic [63:0] fl;
		logic [4:0] cnt;
		pa = 52'(rand64());
		if ($urandom_range(19) != 0) pa[11:0] = 12'h000;
		fl = rand64();
		if ($urandom_range(3) != 0) fl = fl & 64'h8000_0000_0000_0F7F;
		cnt = ($urandom_range(9) == 0) ? 5'($urandom()) : 5'($urandom_range(4));
		return mk_req($urandom_range(99) < 55 ? OP_MAP : OP_UNMAP, rand_va(), pa, cnt, fl);
	endfunction

	task automatic wait_idle();
		while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_base(input logic [51:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		base_reg = {v[51:12], 12'h000};
	endtask

	task automatic run_random(input int n, input int idle, input int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++) pending_reqs.push_back(rand_req());
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_req = '0;
		in_taken = 1'b0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		errors = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		hold_req = 1'b0;
		base_reg = '0;
		free_table = 1;
		for (int k = 0; k < NumTables*512; k++) pt_mem[k] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_base(52'h0);
		// directed part
		pending_reqs.push_back(mk_req(OP_MAP, 48'h0, 52'h0, 5'd0, 64'h3));
		pending_reqs.push_back(mk_req(OP_MAP, 48'h1000, 52'h5000, 5'd3, 64'h3));
		pending_reqs.push_back(mk_req(OP_MAP, 48'h3000, 52'h0, 5'd2, 64'h3));
		pending_reqs.push_back(mk_req(OP_MAP, 48'h123, 52'h0, 5'd1, 64'h3));
		pending_reqs.push_back(mk_req(OP_MAP, 48'h8000, 52'h7, 5'd1, 64'h3));
		pending_reqs.push_back(mk_req(OP_UNMAP, 48'h1001, 52'h0, 5'd1, 64'h0));
		pending_reqs.push_back(mk_req(OP_MAP, 48'hFFFF_FFFF_E000, 52'hF_FFFF_FFFF_E000,
			5'd31, 64'hFFFF_FFFF_FFFF_FFFF));
		// large page flag in a directory entry via a leaf written into a table slot
		pending_reqs.push_back(mk_req(OP_MAP, 48'h40_0000, 52'h0, 5'd1, 64'h83));
		pending_reqs.push_back(mk_req(OP_UNMAP, 48'h0, 52'h0, 5'd16, 64'h0));
		pending_reqs.push_back(mk_req(OP_UNMAP, 48'hFFFF_FFFF_E000, 52'h0, 5'd31, 64'h0));
		pending_reqs.push_back(mk_req(OP_UNMAP, 48'h7000_0000_0000, 52'h0, 5'd2, 64'h0));
		wait_idle();

		run_random(60, 0, 0);
		// move the pool: old pointers become foreign
		write_base(52'hF_FFFF_FFFF_FFFF);
		run_random(40, 66, 0);
		write_base(52'h0_0000_0004_0000);
		run_random(40, 0, 66);
		write_base(52'h0);
		run_random(40, 25, 25);

		// long receiver hold-off while requests keep coming
		hold_req = 1'b1;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < 40; i++) pending_reqs.push_back(rand_req());
		wait (hold_cycles != 0);
		hold_req = 1'b0;
		wait_idle();
		run_random(30, 0, 0);

		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/ptm_pkg.sv
src/ptm_mem.sv
src/ptm_walk.sv
src/page_table_map_unmap_engine.sv
sim/tb_top.sv
